// ===== design/wsm_pkg.sv =====
`default_nettype none

package wsm_pkg;

   localparam int PATTERN_MAX_DEFAULT = 8;
   localparam int PATTERN_REG_W = 64;
   localparam int PLEN_W = 4;
   localparam int TAB_W = 7;
   localparam int POS_W = 32;
   localparam int LINE_W = 32;
   localparam int COL_W = 24;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_PATTERN_BYTES = 2'd0;
   localparam csr_index_type CSR_PATTERN_LENGTH = 2'd1;
   localparam csr_index_type CSR_IGNORE_CASE = 2'd2;
   localparam csr_index_type CSR_TAB_STOP = 2'd3;

   localparam logic [7:0] CHAR_TAB = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_ANY = 8'h3F;
   localparam logic [7:0] CHAR_NON_WORD = 8'h5E;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   localparam logic [COL_W-1:0] COL_MAX = '1;
   localparam logic [LINE_W-1:0] LINE_MAX = '1;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef struct packed {
      logic [7:0] data;
      logic       eof;
      logic       is_tab;
      logic       is_newline;
      logic       is_word;
   } item_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [TAB_W-1:0] remainder;
   } div_status_type;

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDERSCORE);
   endfunction

   function automatic logic [7:0] fold_upper(input logic [7:0] c, input logic fold);
      if (fold && c >= 8'h61 && c <= 8'h7A) begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/wsm_queue.sv =====
`default_nettype none

module wsm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire wsm_pkg::item_type push_item,
   input  wire logic              pop,
   output wsm_pkg::item_type      head,
   output logic                   head_valid,
   output logic                   full
);

   localparam int DEPTH = wsm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wsm_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/wsm_front.sv =====
`default_nettype none

module wsm_front (
   input  wire logic        req_valid,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_file,
   input  wire logic        queue_full,
   input  wire logic        back_busy,
   output logic             req_stall,
   output logic             push,
   output wsm_pkg::item_type item
);

   assign req_stall = queue_full | back_busy;
   assign push = req_valid & ~req_stall;

   always_comb begin
      item.data = req_data_byte;
      item.eof = req_end_of_file;
      item.is_tab = (req_data_byte == wsm_pkg::CHAR_TAB);
      item.is_newline = (req_data_byte == wsm_pkg::CHAR_NEWLINE);
      item.is_word = wsm_pkg::is_word_char(req_data_byte);
   end

endmodule

`default_nettype wire

// ===== design/wsm_phase_div.sv =====
`default_nettype none

// remainder of dividend / divisor, one quotient bit per cycle
module wsm_phase_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [wsm_pkg::COL_W-1:0] dividend,
   input  wire logic [wsm_pkg::TAB_W-1:0] divisor,
   output wsm_pkg::div_status_type        status
);

   localparam int N = wsm_pkg::COL_W;
   localparam int W = wsm_pkg::TAB_W;
   localparam int CNT_W = $clog2(N + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             done_ff, done_in;
   logic [N-1:0]     dvd_ff, dvd_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W:0]       trial;

   always_comb begin
      trial = {rem_ff, dvd_ff[N-1]};
      count_in = count_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      done_in = 1'b0;
      if (start) begin
         count_in = CNT_W'(N);
         dvd_in = dividend;
         rem_in = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         dvd_in = {dvd_ff[N-2:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? W'(trial - {1'b0, divisor}) : W'(trial);
         done_in = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;
   assign status.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== design/wsm_back.sv =====
`default_nettype none

module wsm_back #(
   parameter int PATTERN_MAX = wsm_pkg::PATTERN_MAX_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire wsm_pkg::item_type                 item,
   input  wire logic                              item_valid,
   output logic                                   item_pop,
   input  wire logic [wsm_pkg::PATTERN_REG_W-1:0] pattern_bytes,
   input  wire logic [wsm_pkg::PLEN_W-1:0]        pattern_length,
   input  wire logic                              ignore_case,
   input  wire logic [wsm_pkg::TAB_W-1:0]         tab_stop,
   input  wire logic                              tab_start,
   output logic                                   busy,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [wsm_pkg::POS_W-1:0]              rsp_match_position,
   output logic [wsm_pkg::LINE_W-1:0]             rsp_match_line,
   output logic [wsm_pkg::COL_W-1:0]              rsp_match_column
);

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int PLEN_W = wsm_pkg::PLEN_W;
   localparam int TAB_W = wsm_pkg::TAB_W;
   localparam int POS_W = wsm_pkg::POS_W;
   localparam int LINE_W = wsm_pkg::LINE_W;
   localparam int COL_W = wsm_pkg::COL_W;

   // sliding window, entry k = byte received k items ago
   logic [7:0]        win_byte_ff [PATTERN_MAX];
   logic              win_word_ff [PATTERN_MAX];
   logic [LINE_W-1:0] win_line_ff [PATTERN_MAX];
   logic [COL_W-1:0]  win_col_ff  [PATTERN_MAX];
   logic [7:0]        nw_byte [PATTERN_MAX];
   logic              nw_word [PATTERN_MAX];
   logic [LINE_W-1:0] nw_line [PATTERN_MAX];
   logic [COL_W-1:0]  nw_col  [PATTERN_MAX];

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [TAB_W-1:0]  phase_ff, phase_in;    // col_ff mod tab while col_ff below max

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [LINE_W-1:0] rsp_line_ff;
   logic [COL_W-1:0]  rsp_col_ff;

   wsm_pkg::div_status_type div_status;

   logic [PLEN_W-1:0] plen_clip;
   logic [IDX_W-1:0]  len_m1;
   logic [TAB_W-1:0]  tab_eff;
   logic [TAB_W-1:0]  tab_adv;
   logic [COL_W:0]    tab_sum;
   logic [COL_W-1:0]  col_rec;
   logic [LINE_W-1:0] line_rec;
   logic [TAB_W-1:0]  phase_base;
   logic [TAB_W:0]    phase_inc;
   logic              cmp_ok;
   logic              hit;
   logic [7:0]        pc;
   logic [7:0]        dc;
   logic              dw;
   logic [IDX_W-1:0]  idx;

   wsm_phase_div u_phase_div (
      .clock    (clock),
      .reset    (reset),
      .start    (tab_start),
      .dividend (col_ff),
      .divisor  (tab_eff),
      .status   (div_status)
   );

   assign busy = div_status.busy;
   assign item_pop = item_valid & ~div_status.busy & ~div_status.done &
                     (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      if (pattern_length == '0) begin
         plen_clip = PLEN_W'(1);
      end else if (pattern_length > PLEN_W'(PATTERN_MAX)) begin
         plen_clip = PLEN_W'(PATTERN_MAX);
      end else begin
         plen_clip = pattern_length;
      end
      len_m1 = IDX_W'(plen_clip - PLEN_W'(1));
   end

   assign tab_eff = (tab_stop == '0) ? TAB_W'(1) : tab_stop;
   assign tab_adv = tab_eff - phase_ff;
   assign tab_sum = {1'b0, col_ff} + (COL_W + 1)'(tab_adv);

   always_comb begin
      if (item.is_tab) begin
         col_rec = tab_sum[COL_W] ? wsm_pkg::COL_MAX : tab_sum[COL_W-1:0];
         phase_base = '0;
      end else if (item.is_newline) begin
         col_rec = '0;
         phase_base = '0;
      end else begin
         col_rec = col_ff;
         phase_base = phase_ff;
      end
      if (item.is_newline && line_ff != wsm_pkg::LINE_MAX) begin
         line_rec = line_ff + 1'b1;
      end else begin
         line_rec = line_ff;
      end
      phase_inc = {1'b0, phase_base} + (TAB_W + 1)'(1);
   end

   always_comb begin
      nw_byte[0] = item.data;
      nw_word[0] = item.is_word;
      nw_line[0] = line_rec;
      nw_col[0] = col_rec;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         nw_byte[k] = win_byte_ff[k-1];
         nw_word[k] = win_word_ff[k-1];
         nw_line[k] = win_line_ff[k-1];
         nw_col[k] = win_col_ff[k-1];
      end
   end

   always_comb begin
      cmp_ok = 1'b1;
      pc = '0;
      dc = '0;
      dw = 1'b0;
      idx = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (IDX_W'(j) <= len_m1) begin
            idx = len_m1 - IDX_W'(j);
            pc = pattern_bytes[8*j +: 8];
            dc = nw_byte[idx];
            dw = nw_word[idx];
            if (!((pc == wsm_pkg::CHAR_ANY) ||
                  (pc == wsm_pkg::CHAR_NON_WORD && !dw) ||
                  (wsm_pkg::fold_upper(dc, ignore_case) ==
                   wsm_pkg::fold_upper(pc, ignore_case)))) begin
               cmp_ok = 1'b0;
            end
         end
      end
      hit = cmp_ok && (pos_ff >= POS_W'(len_m1));
   end

   always_comb begin
      pos_in = pos_ff;
      line_in = line_ff;
      col_in = col_ff;
      phase_in = phase_ff;
      if (div_status.done) begin
         phase_in = div_status.remainder;
      end else if (item_pop) begin
         if (item.eof) begin
            pos_in = '0;
            line_in = '0;
            col_in = '0;
            phase_in = '0;
         end else begin
            pos_in = (pos_ff == wsm_pkg::POS_MAX) ? pos_ff : pos_ff + 1'b1;
            line_in = line_rec;
            col_in = (col_rec == wsm_pkg::COL_MAX) ? col_rec : col_rec + 1'b1;
            phase_in = (phase_inc == {1'b0, tab_eff}) ? '0 : phase_inc[TAB_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_pop) begin
         rsp_valid_in = hit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         line_ff <= '0;
         col_ff <= '0;
         phase_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         line_ff <= line_in;
         col_ff <= col_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            win_byte_ff[k] <= nw_byte[k];
            win_word_ff[k] <= nw_word[k];
            win_line_ff[k] <= nw_line[k];
            win_col_ff[k] <= nw_col[k];
         end
      end
      if (item_pop && hit) begin
         rsp_pos_ff <= (pos_ff == wsm_pkg::POS_MAX) ? pos_ff : pos_ff - POS_W'(len_m1);
         rsp_line_ff <= nw_line[len_m1];
         rsp_col_ff <= nw_col[len_m1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_match_line = rsp_line_ff;
   assign rsp_match_column = rsp_col_ff;

endmodule

`default_nettype wire

// ===== design/wildcard_substring_matcher.sv =====
`default_nettype none

// Wildcard substring matcher. Bytes of a file arrive one per transaction on the req_ channel;
// each time the newest pattern_length bytes match the pattern ('?' any byte, '^' any byte
// that is not a letter, digit or underscore, optional case folding) one transaction with the
// start byte's position, line and tab-expanded column leaves on the rsp_ channel from a
// response register once the completing byte has passed the queue. A two-entry queue
// separates the input side from the matching datapath, so one byte per cycle is sustained
// while no result stalls and no remainder runs; a stalled result does not stop input until
// the queue fills. Column tracking keeps the position within the tab stop incrementally;
// writing tab_stop starts a bit-serial remainder over the 24-bit column that rebuilds it,
// and input is held until it is done. end_of_file on a byte clears the position, line and
// column after that byte. Registers sit on a 64-bit APB port at byte address 8 * index.
module wildcard_substring_matcher #(
   parameter int PATTERN_MAX = wsm_pkg::PATTERN_MAX_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_data_byte,
   input  wire logic                                req_end_of_file,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [wsm_pkg::POS_W-1:0]                rsp_match_position,
   output logic [wsm_pkg::LINE_W-1:0]               rsp_match_line,
   output logic [wsm_pkg::COL_W-1:0]                rsp_match_column,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [wsm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [wsm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [wsm_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);

   localparam int DATA_W = wsm_pkg::CSR_DATA_W;

   logic [wsm_pkg::PATTERN_REG_W-1:0] pattern_bytes_ff, pattern_bytes_in;
   logic [wsm_pkg::PLEN_W-1:0]        pattern_length_ff, pattern_length_in;
   logic                              ignore_case_ff, ignore_case_in;
   logic [wsm_pkg::TAB_W-1:0]         tab_stop_ff, tab_stop_in;
   logic                              tab_start_ff, tab_start_in;

   wsm_pkg::csr_index_type csr_index;
   logic                   csr_write;

   wsm_pkg::item_type front_item;
   wsm_pkg::item_type queue_head;
   logic              front_push;
   logic              queue_valid;
   logic              queue_full;
   logic              queue_pop;
   logic              back_busy;
   logic              input_hold;

   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[wsm_pkg::CSR_ADDR_W-1:3];
   assign csr_write = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      pattern_bytes_in = pattern_bytes_ff;
      pattern_length_in = pattern_length_ff;
      ignore_case_in = ignore_case_ff;
      tab_stop_in = tab_stop_ff;
      tab_start_in = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            wsm_pkg::CSR_PATTERN_BYTES: begin
               pattern_bytes_in = csr_pwdata[wsm_pkg::PATTERN_REG_W-1:0];
            end
            wsm_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_in = csr_pwdata[wsm_pkg::PLEN_W-1:0];
            end
            wsm_pkg::CSR_IGNORE_CASE: begin
               ignore_case_in = csr_pwdata[0];
            end
            wsm_pkg::CSR_TAB_STOP: begin
               tab_stop_in = csr_pwdata[wsm_pkg::TAB_W-1:0];
               tab_start_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         wsm_pkg::CSR_PATTERN_BYTES:  csr_prdata = DATA_W'(pattern_bytes_ff);
         wsm_pkg::CSR_PATTERN_LENGTH: csr_prdata = DATA_W'(pattern_length_ff);
         wsm_pkg::CSR_IGNORE_CASE:    csr_prdata = DATA_W'(ignore_case_ff);
         wsm_pkg::CSR_TAB_STOP:       csr_prdata = DATA_W'(tab_stop_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff <= '0;
         pattern_length_ff <= wsm_pkg::PLEN_W'(1);
         ignore_case_ff <= 1'b1;
         tab_stop_ff <= wsm_pkg::TAB_W'(4);
         tab_start_ff <= 1'b0;
      end else begin
         pattern_bytes_ff <= pattern_bytes_in;
         pattern_length_ff <= pattern_length_in;
         ignore_case_ff <= ignore_case_in;
         tab_stop_ff <= tab_stop_in;
         tab_start_ff <= tab_start_in;
      end
   end

   assign input_hold = back_busy | tab_start_ff;

   wsm_front u_front (
      .req_valid       (req_valid),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .queue_full      (queue_full),
      .back_busy       (input_hold),
      .req_stall       (req_stall),
      .push            (front_push),
      .item            (front_item)
   );

   wsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_item  (front_item),
      .pop        (queue_pop),
      .head       (queue_head),
      .head_valid (queue_valid),
      .full       (queue_full)
   );

   wsm_back #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .item               (queue_head),
      .item_valid         (queue_valid),
      .item_pop           (queue_pop),
      .pattern_bytes      (pattern_bytes_ff),
      .pattern_length     (pattern_length_ff),
      .ignore_case        (ignore_case_ff),
      .tab_stop           (tab_stop_ff),
      .tab_start          (tab_start_ff),
      .busy               (back_busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_match_position (rsp_match_position),
      .rsp_match_line     (rsp_match_line),
      .rsp_match_column   (rsp_match_column)
   );

endmodule

`default_nettype wire
